// ===== hdl/vrsc_pkg.sv =====
// ----------------------------------------------------------------------------
// vrsc_pkg : shared types and constants for the route split cost block
// Widths, cell row length and control bundles for the window and min-queue
// cell rows, plus the saturating cost adder.
// ----------------------------------------------------------------------------
package vrsc_pkg;

    localparam int MAX_CLIENTS = 1024;
    localparam int POS_W       = $clog2(MAX_CLIENTS);
    localparam int CNT_W       = POS_W + 1;
    localparam int DEMAND_W    = 16;
    localparam int DIST_W      = 32;
    localparam int DETOUR_W    = DIST_W + 1;
    localparam int COST_W      = 48;
    localparam int CAP_W       = 24;
    localparam int LOAD_W      = DEMAND_W + POS_W;
    localparam int CMP_W       = (LOAD_W > CAP_W) ? LOAD_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(65535);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PATH,
        S_COST,
        S_PUSH,
        S_POP,
        S_CLOSE,
        S_SUM
    } state_t;

    // one client slot of the capacity window
    typedef struct packed {
        logic                valid;
        logic [DEMAND_W-1:0] demand;
    } win_entry_t;

    typedef struct packed {
        logic                push;
        logic                pop;
        logic                clear;
        logic [DEMAND_W-1:0] demand;
    } win_ctl_t;

    // one route start held in the min-queue
    typedef struct packed {
        logic              valid;
        logic [COST_W-1:0] cost;
        logic [POS_W-1:0]  pos;
    } dq_entry_t;

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              clear;
        logic [COST_W-1:0] cost;
        logic [POS_W-1:0]  pos;
    } dq_ctl_t;

    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

endpackage

// ===== hdl/vrsc_win_cell.sv =====
// ----------------------------------------------------------------------------
// vrsc_win_cell : one slot of the demand window row
// Holds one client demand; shifts towards the head on a pop and takes the
// new demand when it is the first free slot on a push.
// ----------------------------------------------------------------------------
module vrsc_win_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  vrsc_pkg::win_ctl_t   ctl,
    input  logic                 left_valid,
    input  vrsc_pkg::win_entry_t right,
    output vrsc_pkg::win_entry_t entry
);
    import vrsc_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [DEMAND_W-1:0] demand_reg;
    logic [DEMAND_W-1:0] demand_next;

    always_comb
    begin
        valid_next  = valid_reg;
        demand_next = demand_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            // advance towards the head
            valid_next  = right.valid;
            demand_next = right.demand;
        end
        else if (ctl.push && !valid_reg && left_valid)
        begin
            valid_next  = 1'b1;
            demand_next = ctl.demand;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        demand_reg <= demand_next;
    end

    assign entry.valid  = valid_reg;
    assign entry.demand = demand_reg;

endmodule

// ===== hdl/vrsc_dq_cell.sv =====
// ----------------------------------------------------------------------------
// vrsc_dq_cell : one slot of the monotonic min-queue row
// Holds a split cost and its route start; drops itself when a push brings a
// cost no larger, and shifts towards the head on a pop.
// ----------------------------------------------------------------------------
module vrsc_dq_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  vrsc_pkg::dq_ctl_t   ctl,
    input  logic                left_keep,
    input  vrsc_pkg::dq_entry_t right,
    output vrsc_pkg::dq_entry_t entry,
    output logic                keep
);
    import vrsc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [COST_W-1:0] cost_reg;
    logic [COST_W-1:0] cost_next;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;

    // survives a push only if strictly cheaper than the incoming cost
    assign keep = valid_reg && (cost_reg < ctl.cost);

    always_comb
    begin
        valid_next = valid_reg;
        cost_next  = cost_reg;
        pos_next   = pos_reg;
        if (ctl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctl.pop)
        begin
            valid_next = right.valid;
            cost_next  = right.cost;
            pos_next   = right.pos;
        end
        else if (ctl.push)
        begin
            valid_next = keep || left_keep;
            if (!keep && left_keep)
            begin
                cost_next = ctl.cost;
                pos_next  = ctl.pos;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cost_reg <= cost_next;
        pos_reg  <= pos_next;
    end

    assign entry.valid = valid_reg;
    assign entry.cost  = cost_reg;
    assign entry.pos   = pos_reg;

endmodule

// ===== hdl/vrp_route_split_cost.sv =====
// ----------------------------------------------------------------------------
// vrp_route_split_cost : optimal split cost of one giant tour
// Clients arrive in tour order, one transfer each; the last client of a tour
// brings one result transfer with the depot-closed path cost plus the best
// split cost (40.8 fixed point), or the overload flag with a zero cost when
// a single demand exceeds the truck capacity or the tour is longer than the
// cell rows. The block works on one client at a time: an ordinary client
// passes the path, cost, push and pop steps, one more pop for every client
// leaving the capacity window, and the last client adds a close and a sum
// step; the sequencer drives push, pop and clear into the two cell rows (a
// demand window and a monotonic min-queue of split costs, MAX_CLIENTS cells
// each). Results sit in an output register, so the next client is taken while
// a result waits; a second result stalls only until the first is transferred.
// The capacity register may be written whenever the block is idle.
// ----------------------------------------------------------------------------
module vrp_route_split_cost (
    input  logic                            clk,
    input  logic                            rst_n,
    // capacity register
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [vrsc_pkg::CAP_W-1:0]      cfg_data,
    // client channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [vrsc_pkg::DEMAND_W-1:0]   client_demand,
    input  logic [vrsc_pkg::DIST_W-1:0]     depot_distance,
    input  logic [vrsc_pkg::DIST_W-1:0]     step_distance,
    input  logic                            last_client,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [vrsc_pkg::COST_W-1:0]     total_cost,
    output logic                            overload_error
);
    import vrsc_pkg::*;

    state_t               state_reg;
    state_t               state_next;

    logic [CAP_W-1:0]     cap_reg;
    logic [LOAD_W-1:0]    load_reg;
    logic [LOAD_W-1:0]    load_next;
    logic [COST_W-1:0]    path_reg;
    logic [COST_W-1:0]    path_next;
    logic [DIST_W-1:0]    prev_depot_reg;
    logic [DIST_W-1:0]    prev_depot_next;
    logic [CNT_W-1:0]     wsp_reg;
    logic [CNT_W-1:0]     wsp_next;
    logic [CNT_W-1:0]     pos_reg;
    logic [CNT_W-1:0]     pos_next;
    logic                 error_reg;
    logic                 error_next;
    logic [DETOUR_W-1:0]  detour_reg;
    logic [DETOUR_W-1:0]  detour_next;
    logic [COST_W-1:0]    new_cost_reg;
    logic [COST_W-1:0]    new_cost_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [COST_W-1:0]    total_reg;
    logic [COST_W-1:0]    total_next;
    logic                 overload_reg;
    logic                 overload_next;

    // captured client
    logic [DEMAND_W-1:0]  demand_reg;
    logic [DIST_W-1:0]    depot_reg;
    logic [DIST_W-1:0]    step_reg;
    logic                 last_reg;

    win_ctl_t             win_ctl;
    dq_ctl_t              dq_ctl;
    win_entry_t           win_row [MAX_CLIENTS];
    dq_entry_t            dq_row  [MAX_CLIENTS];
    logic [MAX_CLIENTS-1:0] dq_keep;

    logic                 in_xfer;
    logic                 pos_full;
    logic                 first_client;
    logic                 pop_go;
    logic                 out_free;
    logic [COST_W-1:0]    min_cost;
    logic [DETOUR_W-1:0]  around;

    assign cfg_ready    = 1'b1;
    assign in_xfer      = in_valid && in_ready;
    assign pos_full     = (pos_reg == CNT_W'(MAX_CLIENTS));
    assign first_client = (pos_reg == '0);
    // an empty queue counts as a zero minimum
    assign min_cost     = dq_row[0].valid ? dq_row[0].cost : '0;
    assign around       = {1'b0, prev_depot_reg} + {1'b0, depot_reg};
    // drop the oldest client while the truck is overfull and the window holds one
    assign pop_go       = (CMP_W'(load_reg) > CMP_W'(cap_reg)) && win_row[0].valid;
    assign out_free     = !out_valid_reg || out_ready;

    // ------------------------------------------------------------------------
    // Cell rows: head at index 0, each cell sees its neighbours only
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < MAX_CLIENTS; i++)
    begin : g_row
        logic       win_left_valid;
        win_entry_t win_right;
        logic       dq_left_keep;
        dq_entry_t  dq_right;

        if (i == 0)
        begin : g_head
            assign win_left_valid = 1'b1;
            assign dq_left_keep   = 1'b1;
        end
        else
        begin : g_body
            assign win_left_valid = win_row[i-1].valid;
            assign dq_left_keep   = dq_keep[i-1];
        end

        if (i == MAX_CLIENTS - 1)
        begin : g_tail
            assign win_right = '0;
            assign dq_right  = '0;
        end
        else
        begin : g_inner
            assign win_right = win_row[i+1];
            assign dq_right  = dq_row[i+1];
        end

        vrsc_win_cell u_win_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (win_ctl),
            .left_valid (win_left_valid),
            .right      (win_right),
            .entry      (win_row[i])
        );

        vrsc_dq_cell u_dq_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (dq_ctl),
            .left_keep (dq_left_keep),
            .right     (dq_right),
            .entry     (dq_row[i]),
            .keep      (dq_keep[i])
        );
    end

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_PATH;
                end
            end
            S_PATH:
            begin
                if (pos_full)
                begin
                    state_next = last_reg ? S_CLOSE : S_IDLE;
                end
                else
                begin
                    state_next = S_COST;
                end
            end
            S_COST:
            begin
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                state_next = S_POP;
            end
            S_POP:
            begin
                if (!pop_go)
                begin
                    state_next = last_reg ? S_CLOSE : S_IDLE;
                end
            end
            S_CLOSE:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: strobes into the cell rows
    // ------------------------------------------------------------------------
    always_comb
    begin
        in_ready       = 1'b0;
        win_ctl        = '0;
        dq_ctl         = '0;
        win_ctl.demand = demand_reg;
        dq_ctl.cost    = new_cost_reg;
        dq_ctl.pos     = pos_reg[POS_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
            end
            S_PUSH:
            begin
                win_ctl.push = 1'b1;
                dq_ctl.push  = 1'b1;
            end
            S_POP:
            begin
                win_ctl.pop = pop_go;
                // the queue head leaves with the window client it started at
                dq_ctl.pop  = pop_go && dq_row[0].valid &&
                              ({1'b0, dq_row[0].pos} == wsp_reg);
            end
            S_SUM:
            begin
                win_ctl.clear = out_free;
                dq_ctl.clear  = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Datapath: path sum, window load, split cost and result
    // ------------------------------------------------------------------------
    always_comb
    begin
        load_next       = load_reg;
        path_next       = path_reg;
        prev_depot_next = prev_depot_reg;
        wsp_next        = wsp_reg;
        pos_next        = pos_reg;
        error_next      = error_reg;
        detour_next     = detour_reg;
        new_cost_next   = new_cost_reg;
        out_valid_next  = out_valid_reg;
        total_next      = total_reg;
        overload_next   = overload_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_PATH:
            begin
                if (pos_full)
                begin
                    // tour longer than the rows: flag and skip the client
                    error_next = 1'b1;
                end
                else if (first_client)
                begin
                    path_next   = COST_W'(depot_reg);
                    detour_next = '0;
                end
                else
                begin
                    path_next   = sat_add(path_reg, COST_W'(step_reg));
                    // a negative detour counts as zero
                    detour_next = (around > DETOUR_W'(step_reg)) ?
                                  around - DETOUR_W'(step_reg) : '0;
                end
            end
            S_COST:
            begin
                new_cost_next = first_client ? '0 :
                                sat_add(min_cost, COST_W'(detour_reg));
            end
            S_PUSH:
            begin
                load_next = load_reg + LOAD_W'(demand_reg);
            end
            S_POP:
            begin
                if (pop_go)
                begin
                    load_next = load_reg - LOAD_W'(win_row[0].demand);
                    wsp_next  = wsp_reg + CNT_W'(1);
                end
                else
                begin
                    // empty window: this client alone overloads the truck
                    if (!win_row[0].valid)
                    begin
                        error_next = 1'b1;
                    end
                    prev_depot_next = depot_reg;
                    pos_next        = pos_reg + CNT_W'(1);
                end
            end
            S_CLOSE:
            begin
                path_next = sat_add(path_reg, COST_W'(depot_reg));
            end
            S_SUM:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    total_next      = error_reg ? '0 : sat_add(path_reg, min_cost);
                    overload_next   = error_reg;
                    // back to the empty tour
                    load_next       = '0;
                    path_next       = '0;
                    prev_depot_next = '0;
                    wsp_next        = '0;
                    pos_next        = '0;
                    error_next      = 1'b0;
                end
            end
            default:
            begin
                error_next = error_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cap_reg        <= CAP_RESET;
            load_reg       <= '0;
            path_reg       <= '0;
            prev_depot_reg <= '0;
            wsp_reg        <= '0;
            pos_reg        <= '0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            load_reg       <= load_next;
            path_reg       <= path_next;
            prev_depot_reg <= prev_depot_next;
            wsp_reg        <= wsp_next;
            pos_reg        <= pos_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge clk)
    begin
        detour_reg   <= detour_next;
        new_cost_reg <= new_cost_next;
        total_reg    <= total_next;
        overload_reg <= overload_next;
        if (in_xfer)
        begin
            demand_reg <= client_demand;
            depot_reg  <= depot_distance;
            step_reg   <= step_distance;
            last_reg   <= last_client;
        end
    end

    assign out_valid      = out_valid_reg;
    assign total_cost     = total_reg;
    assign overload_error = overload_reg;

endmodule
